// ===== rtl/core/ltr_pkg.sv =====
package ltr_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_COLS      = 2'd1;
  localparam logic [1:0] REG_ROWS      = 2'd2;

  // Register values after reset
  localparam logic [7:0] THRESHOLD_RESET = 8'd50;
  localparam logic [6:0] COLS_RESET      = 7'd27;
  localparam logic [6:0] ROWS_RESET      = 7'd24;

  // Result field widths
  localparam int CORNER_W = 6;
  localparam int AREA_W   = 13;
  localparam int RESULT_W = 40;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HGT  = 5'b00010,
    ST_POP  = 5'b00100,
    ST_LOAD = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage

// ===== rtl/core/largest_threshold_rectangle.sv =====
// Each accepted cell steps through ST_HGT, which updates its column height, and then ST_POP;
// each stack entry it pops forms a candidate, and a pop that leaves entries behind passes
// through ST_LOAD to read the new top from the stack memory. The last cell of a row also pops
// for the row flush with a zero-height bar; the last cell of a frame then waits in ST_FIN to
// load the result register, held while a result waits. The input is not ready for a new cell
// until the last one is through; each cell is pushed and popped at most once. Reset: sync.
module largest_threshold_rectangle
  import ltr_pkg::*;
#(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                clk,
  input  logic                rst,
  // s_axis_tdata: cell_value[7:0]
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  // s_axis_tuser: frame_start[0]
  input  logic                s_axis_tuser,
  // m_axis_tdata: found[0], top_row[6:1], left_col[12:7], bottom_row[18:13],
  // right_col[24:19], best_area[37:25], zero[39:38]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [RESULT_W-1:0] m_axis_tdata,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  localparam int CW  = $clog2(MAX_COLS);
  localparam int CJW = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int HW  = $clog2(MAX_ROWS + 1);
  localparam int AW  = HW + CJW;
  localparam int SW  = CW + HW;

  state_t state;

  logic [7:0] threshold;
  logic [6:0] cols_in_use;
  logic [6:0] rows_in_use;

  logic [CJW-1:0] cols_eff;
  logic [HW-1:0]  rows_eff;

  // Column heights and their per-frame valid bits
  logic [HW-1:0]       hgt_mem [MAX_COLS];
  logic [MAX_COLS-1:0] hgt_valid;
  logic [HW-1:0]       hgt_rdata;
  logic [CW-1:0]       hgt_raddr;
  logic                hgt_re;
  logic                hgt_we;
  logic [HW-1:0]       h_new;

  // Stack of open bars: start column and height
  logic [SW-1:0]  stk_mem [MAX_COLS];
  logic [SW-1:0]  stk_rdata;
  logic [CW-1:0]  stk_raddr;
  logic [CW-1:0]  stk_waddr;
  logic           stk_re;
  logic           stk_we;
  logic [CJW-1:0] sp;
  logic [HW-1:0]  top_h;
  logic [CW-1:0]  top_start;

  // Current bar
  logic [CJW-1:0] cur_j;
  logic [HW-1:0]  cur_h;
  logic [CW-1:0]  cur_start;
  logic           is_set;
  logic           end_bar;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;

  // Candidate rectangle, compared in the cycle after it is formed
  logic          cand_valid;
  logic [AW-1:0] cand_area;
  logic [RW-1:0] cand_top;
  logic [CW-1:0] cand_left;
  logic [RW-1:0] cand_bottom;
  logic [CW-1:0] cand_right;
  logic          take;

  logic [AW-1:0] best_area;
  logic [RW-1:0] best_top;
  logic [CW-1:0] best_left;
  logic [RW-1:0] best_bottom;
  logic [CW-1:0] best_right;

  logic pop_cond;
  logic push_cond;
  logic in_fire;
  logic emit;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Load the result once the last candidate is settled and the output is free
  assign emit = (state == ST_FIN) && !cand_valid && (!m_axis_tvalid || m_axis_tready);

  // Clamp the sizes to 1..MAX
  always_comb begin
    if (cols_in_use == 7'd0) begin
      cols_eff = CJW'(1);
    end else if (32'(cols_in_use) > MAX_COLS) begin
      cols_eff = CJW'(MAX_COLS);
    end else begin
      cols_eff = CJW'(cols_in_use);
    end
    if (rows_in_use == 7'd0) begin
      rows_eff = HW'(1);
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      rows_eff = HW'(MAX_ROWS);
    end else begin
      rows_eff = HW'(rows_in_use);
    end
  end

  // Height memory access
  assign hgt_re    = in_fire;
  assign hgt_raddr = s_axis_tuser ? '0 : col_count;
  assign hgt_we    = (state == ST_HGT);

  always_comb begin
    if (!is_set) begin
      h_new = '0;
    end else if (!hgt_valid[cur_j[CW-1:0]]) begin
      h_new = HW'(1);
    end else if (32'(hgt_rdata) >= MAX_ROWS) begin
      h_new = HW'(MAX_ROWS);
    end else begin
      h_new = hgt_rdata + HW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (hgt_we) begin
      hgt_mem[cur_j[CW-1:0]] <= h_new;
    end
    if (hgt_re) begin
      hgt_rdata <= hgt_mem[hgt_raddr];
    end
  end

  // Stack control
  assign pop_cond  = (state == ST_POP) && (sp != '0) && (top_h > cur_h);
  assign push_cond = (state == ST_POP) && !pop_cond && (cur_h != '0) &&
                     ((sp == '0) || (top_h < cur_h));
  assign stk_we    = push_cond;
  assign stk_waddr = sp[CW-1:0];
  assign stk_re    = pop_cond && (sp > CJW'(1));
  assign stk_raddr = CW'(sp - CJW'(2));

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= {cur_start, cur_h};
    end
    if (stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

  // Take a candidate with a larger area, or an equal one on the same bottom row further left, then higher
  always_comb begin
    take = 1'b0;
    if (cand_area > best_area) begin
      take = 1'b1;
    end else if ((cand_area == best_area) && (best_area != '0) &&
                 (best_bottom == cand_bottom)) begin
      take = (cand_left < best_left) ||
             ((cand_left == best_left) && (cand_top < best_top));
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      threshold     <= THRESHOLD_RESET;
      cols_in_use   <= COLS_RESET;
      rows_in_use   <= ROWS_RESET;
      hgt_valid     <= '0;
      sp            <= '0;
      col_count     <= '0;
      row_count     <= '0;
      cand_valid    <= 1'b0;
      best_area     <= '0;
      best_top      <= '0;
      best_left     <= '0;
      best_bottom   <= '0;
      best_right    <= '0;
      end_bar       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop the result once taken
      if (m_axis_tvalid && m_axis_tready && !emit) begin
        m_axis_tvalid <= 1'b0;
      end

      // Register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD: threshold <= cfg_wdata;
          REG_COLS:      cols_in_use <= cfg_wdata[6:0];
          REG_ROWS:      rows_in_use <= cfg_wdata[6:0];
          default: ;
        endcase
      end

      // Compare the pending candidate; a pop forms the next one
      cand_valid <= pop_cond;
      if (cand_valid && take) begin
        best_area   <= cand_area;
        best_top    <= cand_top;
        best_left   <= cand_left;
        best_bottom <= cand_bottom;
        best_right  <= cand_right;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            // Restart the frame on frame_start
            if (s_axis_tuser) begin
              hgt_valid   <= '0;
              sp          <= '0;
              col_count   <= '0;
              row_count   <= '0;
              best_area   <= '0;
              best_top    <= '0;
              best_left   <= '0;
              best_bottom <= '0;
              best_right  <= '0;
            end
            cur_j   <= CJW'(hgt_raddr);
            is_set  <= (s_axis_tdata >= threshold);
            end_bar <= 1'b0;
            state   <= ST_HGT;
          end
        end

        ST_HGT: begin
          hgt_valid[cur_j[CW-1:0]] <= 1'b1;
          cur_h     <= h_new;
          cur_start <= cur_j[CW-1:0];
          state     <= ST_POP;
        end

        ST_POP: begin
          if (pop_cond) begin
            // Close the taller bar on top of the stack
            cand_area   <= AW'(top_h) * AW'(cur_j - CJW'(top_start));
            cand_top    <= (32'(top_h) > 32'(row_count) + 1) ? '0 :
                           RW'(32'(row_count) + 1 - 32'(top_h));
            cand_left   <= top_start;
            cand_bottom <= row_count;
            cand_right  <= CW'(cur_j - CJW'(1));
            cur_start   <= top_start;
            sp          <= sp - CJW'(1);
            if (sp > CJW'(1)) begin
              state <= ST_LOAD;
            end
          end else begin
            if (push_cond) begin
              top_h     <= cur_h;
              top_start <= cur_start;
              sp        <= sp + CJW'(1);
            end
            if (!end_bar) begin
              if (32'(cur_j) + 1 < 32'(cols_eff)) begin
                col_count <= CW'(cur_j + CJW'(1));
                state     <= ST_IDLE;
              end else begin
                // Flush the row with a zero-height bar
                end_bar <= 1'b1;
                cur_j   <= cur_j + CJW'(1);
                cur_h   <= '0;
              end
            end else begin
              sp        <= '0;
              col_count <= '0;
              if (32'(row_count) + 1 < 32'(rows_eff)) begin
                row_count <= row_count + RW'(1);
                state     <= ST_IDLE;
              end else begin
                state <= ST_FIN;
              end
            end
          end
        end

        ST_LOAD: begin
          top_h     <= stk_rdata[HW-1:0];
          top_start <= stk_rdata[SW-1:HW];
          state     <= ST_POP;
        end

        ST_FIN: begin
          // Emit the result once the last candidate is settled
          if (emit) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, AREA_W'(best_area), CORNER_W'(best_right),
                              CORNER_W'(best_bottom), CORNER_W'(best_left),
                              CORNER_W'(best_top), (best_area != '0)};
            hgt_valid   <= '0;
            sp          <= '0;
            col_count   <= '0;
            row_count   <= '0;
            best_area   <= '0;
            best_top    <= '0;
            best_left   <= '0;
            best_bottom <= '0;
            best_right  <= '0;
            state       <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
